[sv/bptq_pkg.sv]
// ----------------------------------------------------------------------------
// bptq_pkg
// Shared types and constants of the banded priority task queue: pool size,
// index widths, result codes, register map and inter-module structs.
// ----------------------------------------------------------------------------
package bptq_pkg;

    // Pool geometry. An index addresses one entry; a pointer may also hold
    // the end-of-list marker, which equals the pool depth.
    localparam int POOL_DEPTH = 16;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int PTR_W      = $clog2(POOL_DEPTH + 1);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(POOL_DEPTH);

    // Payload widths.
    localparam int PRIO_W = 8;
    localparam int CB_W   = 8;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_STACK_BOUNDARY = 2'd0;
    localparam logic [1:0] REG_TIMER_BOUNDARY = 2'd1;
    localparam logic [1:0] REG_APP_MAX        = 2'd2;

    localparam logic [PRIO_W-1:0] RST_STACK_BOUNDARY = 8'd7;
    localparam logic [PRIO_W-1:0] RST_TIMER_BOUNDARY = 8'd12;
    localparam logic [PRIO_W-1:0] RST_APP_MAX        = 8'd13;

    // Word kinds.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_TAKE = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_FULL = 2'd1,
        ERR_BAND = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        BAND_RX  = 2'd0,
        BAND_TX  = 2'd1,
        BAND_APP = 2'd2
    } band_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_BAND_RX,
        ST_BAND_TX,
        ST_BAND_APP,
        ST_WALK,
        ST_WR_NEW,
        ST_WR_PREV,
        ST_UNLINK,
        ST_FINISH
    } state_t;

    // Band boundaries from the register file.
    typedef struct packed {
        logic [PRIO_W-1:0] stack_boundary;
        logic [PRIO_W-1:0] timer_boundary;
        logic [PRIO_W-1:0] app_max;
    } cfg_t;

    // Write request to the entry memory: either a whole entry or only its
    // link field.
    typedef struct packed {
        logic              we_entry;
        logic              we_next;
        logic [IDX_W-1:0]  idx;
        logic [PRIO_W-1:0] prio;
        logic [CB_W-1:0]   cb;
        logic [PTR_W-1:0]  nxt;
    } mem_wr_t;

    // Flags from the shared window comparator.
    typedef struct packed {
        logic ge_lo;
        logic lt_hi;
    } cmp_res_t;

endpackage

[sv/bptq_window_cmp.sv]
// ----------------------------------------------------------------------------
// bptq_window_cmp
// Shared comparator: tests a value against a lower and an upper bound. The
// sequencer uses it for band classification and for every list step.
// ----------------------------------------------------------------------------
module bptq_window_cmp
    import bptq_pkg::*;
(
    input  logic [PRIO_W-1:0] x,
    input  logic [PRIO_W-1:0] lo,
    input  logic [PRIO_W-1:0] hi,
    output cmp_res_t          res
);

    // Both compares are unsigned.
    always_comb
    begin
        res.ge_lo = (x >= lo);
        res.lt_hi = (x < hi);
    end

endmodule

[sv/bptq_entry_mem.sv]
// ----------------------------------------------------------------------------
// bptq_entry_mem
// Task entry storage: priority, callback id and list link of every pool
// entry. One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bptq_entry_mem
    import bptq_pkg::*;
(
    input  logic              clk,
    input  mem_wr_t           wr,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [PRIO_W-1:0] rd_prio,
    output logic [CB_W-1:0]   rd_cb,
    output logic [PTR_W-1:0]  rd_next
);

    logic [PRIO_W-1:0] prio_mem [POOL_DEPTH];
    logic [CB_W-1:0]   cb_mem   [POOL_DEPTH];
    logic [PTR_W-1:0]  next_mem [POOL_DEPTH];

    logic [PRIO_W-1:0] rd_prio_reg;
    logic [CB_W-1:0]   rd_cb_reg;
    logic [PTR_W-1:0]  rd_next_reg;

    // Write port: a whole entry, or only the link of an entry.
    always_ff @(posedge clk)
    begin
        if (wr.we_entry)
        begin
            prio_mem[wr.idx] <= wr.prio;
            cb_mem[wr.idx]   <= wr.cb;
            next_mem[wr.idx] <= wr.nxt;
        end
        else if (wr.we_next)
        begin
            next_mem[wr.idx] <= wr.nxt;
        end
    end

    // Read port, data valid in the cycle after the address.
    always_ff @(posedge clk)
    begin
        rd_prio_reg <= prio_mem[rd_addr];
        rd_cb_reg   <= cb_mem[rd_addr];
        rd_next_reg <= next_mem[rd_addr];
    end

    assign rd_prio = rd_prio_reg;
    assign rd_cb   = rd_cb_reg;
    assign rd_next = rd_next_reg;

endmodule

[sv/bptq_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bptq_cfg_regs
// Register file for the three band boundaries, written and read over the
// APB-style configuration port.
// ----------------------------------------------------------------------------
module bptq_cfg_regs
    import bptq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [PRIO_W-1:0] stack_boundary_reg;
    logic [PRIO_W-1:0] timer_boundary_reg;
    logic [PRIO_W-1:0] app_max_reg;
    logic [1:0]        reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes; an address beyond the map is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_boundary_reg <= RST_STACK_BOUNDARY;
            timer_boundary_reg <= RST_TIMER_BOUNDARY;
            app_max_reg        <= RST_APP_MAX;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_STACK_BOUNDARY: stack_boundary_reg <= pwdata[PRIO_W-1:0];
                REG_TIMER_BOUNDARY: timer_boundary_reg <= pwdata[PRIO_W-1:0];
                REG_APP_MAX:        app_max_reg        <= pwdata[PRIO_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (reg_idx)
            REG_STACK_BOUNDARY: prdata = DATA_W'(stack_boundary_reg);
            REG_TIMER_BOUNDARY: prdata = DATA_W'(timer_boundary_reg);
            REG_APP_MAX:        prdata = DATA_W'(app_max_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.stack_boundary = stack_boundary_reg;
    assign cfg.timer_boundary = timer_boundary_reg;
    assign cfg.app_max        = app_max_reg;

endmodule

[sv/banded_priority_task_queue.sv]
// ----------------------------------------------------------------------------
// banded_priority_task_queue
// Sorted task pool with banded push classification and ranged take.
// ----------------------------------------------------------------------------
// The block handles one word at a time and drops in_ready from acceptance
// until the result is registered. A push runs ST_START (full check), up
// to three band compares, one per cycle through the shared comparator,
// a list walk, then ST_WR_NEW, ST_WR_PREV and ST_FINISH; a take runs
// ST_START, the walk, ST_UNLINK if an entry matches, and ST_FINISH. The
// walk passes at most 16 list entries, one per cycle through the
// registered read port of the entry memory. A full pool or a priority
// outside every band ends a push early. The finished result sits in an
// output register, so a new word is taken while it waits for out_ready.
// ----------------------------------------------------------------------------
module banded_priority_task_queue
    import bptq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // Input channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic [CB_W-1:0]   callback_id,
    input  logic [PRIO_W-1:0] band_min,
    input  logic [PRIO_W-1:0] band_max,
    // Output channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic              done_res,
    output logic [1:0]        error_code,
    output logic [1:0]        wake_band,
    output logic [CB_W-1:0]   taken_callback,
    output logic [PRIO_W-1:0] taken_priority,
    output logic [CNT_W-1:0]  occupancy
);

    cfg_t              cfg;
    cmp_res_t          cmp;
    mem_wr_t           wr;
    logic [PRIO_W-1:0] cmp_x;
    logic [PRIO_W-1:0] cmp_lo;
    logic [PRIO_W-1:0] cmp_hi;
    logic [IDX_W-1:0]  rd_addr;
    logic [PRIO_W-1:0] mem_prio;
    logic [CB_W-1:0]   mem_cb;
    logic [PTR_W-1:0]  mem_next;

    state_t            state_reg, state_next;
    logic              kind_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [CB_W-1:0]   cb_in_reg;
    logic [PRIO_W-1:0] lo_reg;
    logic [PRIO_W-1:0] hi_reg;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [PTR_W-1:0]  cur_reg, cur_next;
    logic [PTR_W-1:0]  prev_reg, prev_next;
    logic [PTR_W-1:0]  nx_reg, nx_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [POOL_DEPTH-1:0] valid_reg, valid_next;

    logic              res_done_reg, res_done_next;
    err_t              res_err_reg, res_err_next;
    band_t             res_band_reg, res_band_next;
    logic [CB_W-1:0]   res_cb_reg, res_cb_next;
    logic [PRIO_W-1:0] res_pr_reg, res_pr_next;

    logic              out_valid_reg;
    logic              done_res_reg;
    logic [1:0]        error_code_reg;
    logic [1:0]        wake_band_reg;
    logic [CB_W-1:0]   taken_callback_reg;
    logic [PRIO_W-1:0] taken_priority_reg;
    logic [CNT_W-1:0]  occupancy_reg;

    logic [IDX_W-1:0]  free_idx;
    logic              pool_full;
    logic              in_fire;
    logic              out_load;

    // Submodules.
    bptq_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bptq_window_cmp u_cmp (
        .x   (cmp_x),
        .lo  (cmp_lo),
        .hi  (cmp_hi),
        .res (cmp)
    );

    bptq_entry_mem u_mem (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_prio (mem_prio),
        .rd_cb   (mem_cb),
        .rd_next (mem_next)
    );

    // Lowest free entry of the pool.
    always_comb
    begin
        free_idx = '0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign pool_full = (count_reg == CNT_W'(POOL_DEPTH));
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // Input word capture.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg  <= kind;
            prio_reg  <= priority_req;
            cb_in_reg <= callback_id;
            lo_reg    <= band_min;
            hi_reg    <= band_max;
        end
    end

    // State and list control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= NIL_PTR;
            count_reg <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // Working registers of the current word.
    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        nx_reg       <= nx_next;
        res_done_reg <= res_done_next;
        res_err_reg  <= res_err_next;
        res_band_reg <= res_band_next;
        res_cb_reg   <= res_cb_next;
        res_pr_reg   <= res_pr_next;
    end

    // Sequencer: next state, comparator operands, memory access.
    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        nx_next       = nx_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        valid_next    = valid_reg;
        res_done_next = res_done_reg;
        res_err_next  = res_err_reg;
        res_band_next = res_band_reg;
        res_cb_next   = res_cb_reg;
        res_pr_next   = res_pr_reg;
        cmp_x         = mem_prio;
        cmp_lo        = lo_reg;
        cmp_hi        = (kind_reg == KIND_PUSH) ? prio_reg : hi_reg;
        rd_addr       = head_reg[IDX_W-1:0];
        wr            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_START;
                end
            end

            ST_START:
            begin
                res_done_next = 1'b0;
                res_err_next  = ERR_NONE;
                res_band_next = BAND_RX;
                res_cb_next   = '0;
                res_pr_next   = '0;
                cur_next      = head_reg;
                prev_next     = NIL_PTR;
                slot_next     = free_idx;
                if (kind_reg == KIND_TAKE)
                begin
                    state_next = ST_WALK;
                end
                else if (pool_full)
                begin
                    res_err_next = ERR_FULL;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    state_next = ST_BAND_RX;
                end
            end

            // Band tests run in order; the first that holds picks the band.
            ST_BAND_RX:
            begin
                cmp_x  = prio_reg;
                cmp_hi = cfg.stack_boundary;
                if (cmp.lt_hi)
                begin
                    res_band_next = BAND_RX;
                    state_next    = ST_WALK;
                end
                else
                begin
                    state_next = ST_BAND_TX;
                end
            end

            ST_BAND_TX:
            begin
                cmp_x  = prio_reg;
                cmp_hi = cfg.timer_boundary;
                if (cmp.lt_hi)
                begin
                    res_band_next = BAND_TX;
                    state_next    = ST_WALK;
                end
                else
                begin
                    state_next = ST_BAND_APP;
                end
            end

            ST_BAND_APP:
            begin
                // app_max < prio means the priority is above every band.
                cmp_x  = cfg.app_max;
                cmp_hi = prio_reg;
                if (!cmp.lt_hi)
                begin
                    res_band_next = BAND_APP;
                    state_next    = ST_WALK;
                end
                else
                begin
                    res_band_next = BAND_RX;
                    res_err_next  = ERR_BAND;
                    state_next    = ST_FINISH;
                end
            end

            // One list entry per cycle; the data of cur is on the read port.
            ST_WALK:
            begin
                if (cur_reg == NIL_PTR)
                begin
                    state_next = (kind_reg == KIND_PUSH) ? ST_WR_NEW : ST_FINISH;
                end
                else if (kind_reg == KIND_PUSH)
                begin
                    if (cmp.lt_hi)
                    begin
                        prev_next = cur_reg;
                        cur_next  = mem_next;
                        rd_addr   = mem_next[IDX_W-1:0];
                    end
                    else
                    begin
                        state_next = ST_WR_NEW;
                    end
                end
                else if (cmp.ge_lo && cmp.lt_hi)
                begin
                    res_done_next = 1'b1;
                    res_cb_next   = mem_cb;
                    res_pr_next   = mem_prio;
                    nx_next       = mem_next;
                    state_next    = ST_UNLINK;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = mem_next;
                    rd_addr   = mem_next[IDX_W-1:0];
                end
            end

            // Write the new entry, linked ahead of cur.
            ST_WR_NEW:
            begin
                wr.we_entry           = 1'b1;
                wr.idx                = slot_reg;
                wr.prio               = prio_reg;
                wr.cb                 = cb_in_reg;
                wr.nxt                = cur_reg;
                valid_next[slot_reg]  = 1'b1;
                count_next            = count_reg + CNT_W'(1);
                res_done_next         = 1'b1;
                state_next            = ST_WR_PREV;
            end

            // Point the predecessor, or the head, at the new entry.
            ST_WR_PREV:
            begin
                if (prev_reg == NIL_PTR)
                begin
                    head_next = PTR_W'(slot_reg);
                end
                else
                begin
                    wr.we_next = 1'b1;
                    wr.idx     = prev_reg[IDX_W-1:0];
                    wr.nxt     = PTR_W'(slot_reg);
                end
                state_next = ST_FINISH;
            end

            // Remove the found entry from the list.
            ST_UNLINK:
            begin
                if (prev_reg == NIL_PTR)
                begin
                    head_next = nx_reg;
                end
                else
                begin
                    wr.we_next = 1'b1;
                    wr.idx     = prev_reg[IDX_W-1:0];
                    wr.nxt     = nx_reg;
                end
                valid_next[cur_reg[IDX_W-1:0]] = 1'b0;
                count_next = count_reg - CNT_W'(1);
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            done_res_reg       <= res_done_reg;
            error_code_reg     <= res_err_reg;
            wake_band_reg      <= res_band_reg;
            taken_callback_reg <= res_cb_reg;
            taken_priority_reg <= res_pr_reg;
            occupancy_reg      <= count_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign done_res       = done_res_reg;
    assign error_code     = error_code_reg;
    assign wake_band      = wake_band_reg;
    assign taken_callback = taken_callback_reg;
    assign taken_priority = taken_priority_reg;
    assign occupancy      = occupancy_reg;

    // The task count always matches the number of valid entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(count_reg))
    else $error("task count differs from valid entries");

    // The list is empty exactly when no task is queued. The head of a push
    // into an empty list is set in the cycle after the count, in ST_WR_PREV.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_WR_PREV) |-> ((count_reg == '0) == (head_reg == NIL_PTR)))
    else $error("list head disagrees with task count");

    // The walk only visits valid entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && cur_reg != NIL_PTR) |-> valid_reg[cur_reg[IDX_W-1:0]])
    else $error("walk reached a free entry");

    // A rejected push never changes the task count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && res_err_reg != ERR_NONE) |-> $stable(count_reg))
    else $error("rejected push changed the pool");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the banded priority task queue
// Pushes and takes words through the valid/ready input channel. A scoreboard
// keeps its own copy of the sorted pool and predicts each result word. The
// three band registers are set over the APB port between phases, and the
// result side stalls on its own pattern, once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import bptq_pkg::*;

    // Register index with no register behind it.
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_OFF_CYCLES = 400;

    // Expected content of one result word.
    typedef struct packed {
        logic              done;
        err_t              err;
        band_t             band;
        logic [CB_W-1:0]   cb;
        logic [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]  occ;
    } queue_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              kind = KIND_PUSH;
    logic [PRIO_W-1:0] priority_req = '0;
    logic [CB_W-1:0]   callback_id = '0;
    logic [PRIO_W-1:0] band_min = '0;
    logic [PRIO_W-1:0] band_max = '0;

    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              done_res;
    logic [1:0]        error_code;
    logic [1:0]        wake_band;
    logic [CB_W-1:0]   taken_callback;
    logic [PRIO_W-1:0] taken_priority;
    logic [CNT_W-1:0]  occupancy;

    // Scoreboard copy of the pool and of the band registers.
    logic              pool_used [POOL_DEPTH];
    logic [PRIO_W-1:0] pool_prio [POOL_DEPTH];
    logic [CB_W-1:0]   pool_cb   [POOL_DEPTH];
    int                pool_link [POOL_DEPTH];
    int                pool_head;
    int                pool_count;
    logic [PRIO_W-1:0] cfg_stack;
    logic [PRIO_W-1:0] cfg_timer;
    logic [PRIO_W-1:0] cfg_app_max;

    queue_result_t pending_results [$];
    int mismatch_count = 0;
    int burst_left = 0;

    // Result side stall state.
    logic hold_off_req = 1'b0;
    int   rx_mode;
    int   rx_left;
    int   rx_tick;
    int   rx_hold_left;

    banded_priority_task_queue dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .priority_req   (priority_req),
        .callback_id    (callback_id),
        .band_min       (band_min),
        .band_max       (band_max),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .done_res       (done_res),
        .error_code     (error_code),
        .wake_band      (wake_band),
        .taken_callback (taken_callback),
        .taken_priority (taken_priority),
        .occupancy      (occupancy)
    );

    always #5 clk = ~clk;

    // Count a mismatch; only the first few are printed.
    function automatic void report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    // Apply one accepted word to the scoreboard pool and return the result
    // word the block must produce for it.
    function automatic queue_result_t pool_apply_word(input logic k,
                                                      input logic [7:0] pr,
                                                      input logic [7:0] cb,
                                                      input logic [7:0] lo,
                                                      input logic [7:0] hi);
        queue_result_t r;
        int slot;
        int prev;
        int cur;
        int steps;
        bit found;
        r = '0;
        r.err = ERR_NONE;
        r.band = BAND_RX;
        prev = POOL_DEPTH;
        cur = pool_head;
        steps = 0;
        found = 1'b0;
        if (k == KIND_PUSH)
        begin
            slot = -1;
            for (int i = 0; i < POOL_DEPTH; i++)
                if (!pool_used[i] && slot < 0)
                    slot = i;
            // The full check wins over the band check.
            if (slot < 0)
                r.err = ERR_FULL;
            else if (pr < cfg_stack)
                r.band = BAND_RX;
            else if (pr < cfg_timer)
                r.band = BAND_TX;
            else if (pr <= cfg_app_max)
                r.band = BAND_APP;
            else
                r.err = ERR_BAND;
            if (r.err == ERR_NONE)
            begin
                // Stop at the first entry of equal or greater priority, so
                // the new entry goes ahead of its equals.
                while (cur < POOL_DEPTH && steps < POOL_DEPTH && pool_prio[cur] < pr)
                begin
                    prev = cur;
                    cur = pool_link[cur];
                    steps++;
                end
                pool_used[slot] = 1'b1;
                pool_prio[slot] = pr;
                pool_cb[slot] = cb;
                pool_link[slot] = cur;
                if (prev < POOL_DEPTH)
                    pool_link[prev] = slot;
                else
                    pool_head = slot;
                pool_count++;
                r.done = 1'b1;
            end
            else
            begin
                r.band = BAND_RX;
            end
        end
        else
        begin
            // Unlink the first entry in list order inside [lo, hi).
            while (!found && cur < POOL_DEPTH && steps < POOL_DEPTH)
            begin
                if (pool_prio[cur] >= lo && pool_prio[cur] < hi)
                begin
                    found = 1'b1;
                    r.done = 1'b1;
                    r.cb = pool_cb[cur];
                    r.prio = pool_prio[cur];
                    if (prev < POOL_DEPTH)
                        pool_link[prev] = pool_link[cur];
                    else
                        pool_head = pool_link[cur];
                    pool_used[cur] = 1'b0;
                    pool_link[cur] = POOL_DEPTH;
                    if (pool_count > 0)
                        pool_count--;
                end
                else
                begin
                    prev = cur;
                    cur = pool_link[cur];
                    steps++;
                end
            end
        end
        r.occ = pool_count[CNT_W-1:0];
        return r;
    endfunction

    // Offer one word, in bursts with random gaps, and log its expected result
    // once it is accepted.
    task automatic send_word(input logic k, input logic [7:0] pr, input logic [7:0] cb,
                             input logic [7:0] lo, input logic [7:0] hi);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        kind <= k;
        priority_req <= pr;
        callback_id <= cb;
        band_min <= lo;
        band_max <= hi;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(pool_apply_word(k, pr, cb, lo, hi));
    endtask

    task automatic push_word(input logic [7:0] pr, input logic [7:0] cb);
        send_word(KIND_PUSH, pr, cb, 8'($urandom), 8'($urandom));
    endtask

    task automatic take_word(input logic [7:0] lo, input logic [7:0] hi);
        send_word(KIND_TAKE, 8'($urandom), 8'($urandom), lo, hi);
    endtask

    // Stop offering words and wait until every expected result has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom_range(0, 16777215)), val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_STACK_BOUNDARY: cfg_stack = val;
            REG_TIMER_BOUNDARY: cfg_timer = val;
            REG_APP_MAX:        cfg_app_max = val;
            default: ;
        endcase
    endtask

    // APB read, checked against the scoreboard copy of the register.
    task automatic reg_read_check(input logic [1:0] idx);
        logic [7:0] want;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_STACK_BOUNDARY: want = cfg_stack;
            REG_TIMER_BOUNDARY: want = cfg_timer;
            default:            want = cfg_app_max;
        endcase
        if (prdata[7:0] !== want)
            report_mismatch($sformatf("register %0d read exp %0d got %0d",
                                      idx, want, prdata[7:0]));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Set all three band registers while the block is idle, and read them back.
    task automatic set_bands(input logic [7:0] s, input logic [7:0] t, input logic [7:0] a);
        wait_drained();
        reg_write(REG_STACK_BOUNDARY, s);
        reg_write(REG_TIMER_BOUNDARY, t);
        reg_write(REG_APP_MAX, a);
        reg_read_check(REG_STACK_BOUNDARY);
        reg_read_check(REG_TIMER_BOUNDARY);
        reg_read_check(REG_APP_MAX);
    endtask

    // Random traffic: push-heavy and take-heavy stretches, priorities mostly
    // inside the accepted range, takes mostly aimed at a queued task.
    task automatic run_random_phase(input int n_words);
        int lim;
        int push_pct;
        int mode_left;
        int idx;
        logic [7:0] p;
        logic [7:0] lo;
        logic [7:0] hi;
        mode_left = 0;
        push_pct = 50;
        for (int n = 0; n < n_words; n++)
        begin
            lim = int'(cfg_stack);
            if (int'(cfg_timer) > lim)
                lim = int'(cfg_timer);
            if (int'(cfg_app_max) + 1 > lim)
                lim = int'(cfg_app_max) + 1;
            if (mode_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 80;
                endcase
                mode_left = $urandom_range(10, 40);
            end
            mode_left--;
            if ($urandom_range(0, 99) < push_pct)
            begin
                if ($urandom_range(0, 9) < 8)
                    p = 8'($urandom_range(0, lim - 1));
                else
                    p = 8'($urandom);
                push_word(p, 8'($urandom));
            end
            else if (pool_count > 0 && $urandom_range(0, 9) < 7)
            begin
                idx = $urandom_range(0, POOL_DEPTH - 1);
                while (!pool_used[idx])
                    idx = (idx + 1) % POOL_DEPTH;
                p = pool_prio[idx];
                lo = $urandom_range(0, 1) ? p : 8'($urandom_range(0, p));
                if (p == 8'hFF)
                    hi = 8'hFF;
                else if ($urandom_range(0, 1))
                    hi = p + 8'd1;
                else
                    hi = 8'($urandom_range(p + 1, 255));
                take_word(lo, hi);
            end
            else
            begin
                take_word(8'($urandom), 8'($urandom));
            end
        end
    endtask

    // Band edges under the reset register values.
    task automatic test_reset_bands();
        take_word(8'd0, 8'd255);
        push_word(8'd0, 8'h00);
        push_word(8'd6, 8'hFF);
        push_word(8'd7, 8'h17);
        push_word(8'd11, 8'h1B);
        push_word(8'd12, 8'h2C);
        push_word(8'd13, 8'h2D);
        push_word(8'd14, 8'h3E);
        push_word(8'd255, 8'h3F);
    endtask

    // Takes with empty, inverted, unmatched and matching ranges.
    task automatic test_take_ranges();
        take_word(8'd5, 8'd5);
        take_word(8'd200, 8'd3);
        take_word(8'd14, 8'd255);
        take_word(8'd7, 8'd12);
        take_word(8'd0, 8'd255);
    endtask

    // Fill the pool with equal priorities, overflow it, then take the newest.
    task automatic test_pool_full();
        for (int i = 0; i < POOL_DEPTH - 4; i++)
            push_word(8'd12, 8'(8'h80 + i));
        push_word(8'd12, 8'hEE);
        push_word(8'd255, 8'hEF);
        take_word(8'd12, 8'd13);
    endtask

    // Every register written and read back; the unused address is ignored.
    task automatic test_register_map();
        set_bands(8'hA5, 8'h5A, 8'hFF);
        reg_write(REG_UNUSED, 8'h33);
        reg_read_check(REG_STACK_BOUNDARY);
        reg_read_check(REG_TIMER_BOUNDARY);
        reg_read_check(REG_APP_MAX);
    endtask

    // Random traffic under several band settings, extremes and misordered.
    task automatic test_band_settings();
        set_bands(RST_STACK_BOUNDARY, RST_TIMER_BOUNDARY, RST_APP_MAX);
        run_random_phase(110);
        set_bands(8'd0, 8'd0, 8'd0);
        run_random_phase(100);
        set_bands(8'd255, 8'd255, 8'd255);
        run_random_phase(110);
        set_bands(8'd200, 8'd50, 8'd100);
        run_random_phase(100);
        set_bands(8'd10, 8'd5, 8'd3);
        run_random_phase(100);
        set_bands(8'd40, 8'd120, 8'd200);
        run_random_phase(110);
        set_bands(8'($urandom), 8'($urandom), 8'($urandom));
        run_random_phase(100);
        set_bands(8'($urandom_range(0, 30)), 8'($urandom_range(20, 60)),
                  8'($urandom_range(40, 90)));
        run_random_phase(100);
    endtask

    // Long result stall while words keep coming, so the input backs up.
    task automatic test_output_hold_off();
        hold_off_req = 1'b1;
        run_random_phase(60);
    endtask

    // Result side: a changing stall pattern, plus a long hold-off on request.
    initial
    begin
        rx_left = 0;
        rx_tick = 0;
        rx_hold_left = 0;
        rx_mode = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rx_hold_left = HOLD_OFF_CYCLES;
            end
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 150);
            end
            rx_left--;
            rx_tick++;
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (rx_tick % 4 == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Compare each result word with the oldest expectation.
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result word with nothing expected");
            end
            else
            begin
                want = pending_results.pop_front();
                if (done_res !== want.done || error_code !== want.err ||
                    wake_band !== want.band || taken_callback !== want.cb ||
                    taken_priority !== want.prio || occupancy !== want.occ)
                    report_mismatch({
                        $sformatf("exp done=%0d err=%0d band=%0d cb=%0d prio=%0d occ=%0d",
                                  want.done, want.err, want.band, want.cb,
                                  want.prio, want.occ),
                        $sformatf(", got done=%0d err=%0d band=%0d cb=%0d prio=%0d occ=%0d",
                                  done_res, error_code, wake_band, taken_callback,
                                  taken_priority, occupancy)});
            end
        end
    end

    // Run limit.
    initial
    begin
        #3000000;
        $display("[banded_priority_task_queue] ERROR");
        $finish;
    end

    // Test sequence.
    initial
    begin
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            pool_used[i] = 1'b0;
            pool_prio[i] = '0;
            pool_cb[i] = '0;
            pool_link[i] = 0;
        end
        pool_head = POOL_DEPTH;
        pool_count = 0;
        cfg_stack = RST_STACK_BOUNDARY;
        cfg_timer = RST_TIMER_BOUNDARY;
        cfg_app_max = RST_APP_MAX;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_bands();
        test_take_ranges();
        test_pool_full();
        wait_drained();
        test_register_map();
        test_band_settings();
        test_output_hold_off();

        wait_drained();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[banded_priority_task_queue] OK");
        else
            $display("[banded_priority_task_queue] ERROR");
        $finish;
    end

endmodule

[banded_priority_task_queue.f]
sv/bptq_pkg.sv
sv/bptq_window_cmp.sv
sv/bptq_entry_mem.sv
sv/bptq_cfg_regs.sv
sv/banded_priority_task_queue.sv
verif/tb_top.sv
